// ===== src/ndc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_pkg
// Shared widths, register indexes, controller command types and helpers
// for the network delay calculator.
// ----------------------------------------------------------------------------
package ndc_pkg;

  localparam int NODES       = 16;
  localparam int NODE_W      = 4;
  localparam int TABLE_DEPTH = NODES * NODES;
  localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

  localparam int TIME_W      = 48;
  localparam int SIZE_W      = 12;
  localparam int WORD_W      = 16;
  localparam int SPAN_W      = 17;
  localparam int TIME16_W    = 16;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam int PACKET_W    = SIZE_W + TIME16_W;
  localparam int LOAD_W      = COUNT_W + TIME16_W - 8;
  localparam int BASE_W      = LOAD_W + 1;

  // remainder unit: DIV_BITS quotient bits resolved per cycle
  localparam int DIV_BITS    = 4;
  localparam int DIV_STEPS   = WORD_W / DIV_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0]  MAX_TIME  = '1;
  localparam logic [COUNT_W-1:0] MAX_COUNT = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALC_MODE     = 3'd0,
    CFG_BASE_TIME     = 3'd1,
    CFG_RANDOM_SPAN   = 3'd2,
    CFG_PER_BYTE_TIME = 3'd3,
    CFG_PER_PACKET_Q8 = 3'd4,
    CFG_ENFORCE_ORDER = 3'd5
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONSTANT = 2'd0,
    MODE_RANDOM   = 2'd1,
    MODE_LOADED   = 2'd2,
    MODE_LOADED_X = 2'd3
  } calc_mode_e;

  typedef enum logic {
    REQ_SENT      = 1'b0,
    REQ_DELIVERED = 1'b1
  } req_type_e;

  typedef struct packed {
    logic [MODE_W-1:0]   calc_mode;
    logic [TIME16_W-1:0] base_time;
    logic [SPAN_W-1:0]   random_span;
    logic [TIME16_W-1:0] per_byte_time;
    logic [TIME16_W-1:0] per_packet_q8;
    logic                enforce_order;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic dec;
    logic div_step;
    logic base;
    logic order;
    logic sum;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_delivered;
    logic out_free;
  } ctrl_status_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] v);
    sat_time = v[TIME_W] ? MAX_TIME : v[TIME_W-1:0];
  endfunction

endpackage

// ===== src/ndc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_if
// Request and result channels of the network delay calculator.
// ----------------------------------------------------------------------------
interface ndc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [ndc_pkg::NODE_W-1:0]         source_node;
  logic [ndc_pkg::NODE_W-1:0]         dest_node;
  logic [ndc_pkg::SIZE_W-1:0]         msg_size;
  logic [ndc_pkg::TIME_W-1:0]         current_time;
  logic [ndc_pkg::WORD_W-1:0]         random_word;

  modport source (
    output valid, req_type, source_node, dest_node, msg_size, current_time,
           random_word,
    input  ready
  );
  modport sink (
    input  valid, req_type, source_node, dest_node, msg_size, current_time,
           random_word,
    output ready
  );
endinterface

interface ndc_out_if;
  logic                       valid;
  logic                       ready;
  logic [ndc_pkg::TIME_W-1:0] delay;

  modport source (output valid, delay, input ready);
  modport sink (input valid, delay, output ready);
endinterface

// ===== src/ndc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ndc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ndc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ndc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output ndc_pkg::cfg_t                     cfg_o
);

  ndc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ndc_pkg::cfg_idx_e'(cfg_index_i))
        ndc_pkg::CFG_CALC_MODE:
          cfg_d.calc_mode = cfg_data_i[ndc_pkg::MODE_W-1:0];
        ndc_pkg::CFG_BASE_TIME:
          cfg_d.base_time = cfg_data_i[ndc_pkg::TIME16_W-1:0];
        ndc_pkg::CFG_RANDOM_SPAN:
          cfg_d.random_span = cfg_data_i[ndc_pkg::SPAN_W-1:0];
        ndc_pkg::CFG_PER_BYTE_TIME:
          cfg_d.per_byte_time = cfg_data_i[ndc_pkg::TIME16_W-1:0];
        ndc_pkg::CFG_PER_PACKET_Q8:
          cfg_d.per_packet_q8 = cfg_data_i[ndc_pkg::TIME16_W-1:0];
        ndc_pkg::CFG_ENFORCE_ORDER:
          cfg_d.enforce_order = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.calc_mode     <= ndc_pkg::MODE_CONSTANT;
      cfg_q.base_time     <= '0;
      cfg_q.random_span   <= ndc_pkg::SPAN_W'(1);
      cfg_q.per_byte_time <= '0;
      cfg_q.per_packet_q8 <= '0;
      cfg_q.enforce_order <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/ndc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_ctrl
// Sequencer: steps one send request through remainder, base, ordering and
// sum, then hands the delay to the output register.
// ----------------------------------------------------------------------------
module ndc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ndc_pkg::ctrl_status_t status_i,
  output ndc_pkg::ctrl_cmd_t    cmd_o,
  output logic                  in_ready_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_BASE  = 6'b000100,
    ST_ORDER = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [ndc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid) begin
          if (status_i.in_delivered) begin
            cmd_o.dec = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            cnt_d      = '0;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == ndc_pkg::DIV_CNT_W'(ndc_pkg::DIV_STEPS - 1)) begin
          state_d = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d    = ST_ORDER;
      end
      ST_ORDER: begin
        cmd_o.order = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ===== src/ndc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndc_dp
// Datapath: remainder unit, byte and load products, per pair arrival table,
// in-transit counter and output register.
// ----------------------------------------------------------------------------
module ndc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ndc_pkg::cfg_t                  cfg_i,
  input  ndc_pkg::ctrl_cmd_t             cmd_i,
  input  logic [ndc_pkg::NODE_W-1:0]     source_node_i,
  input  logic [ndc_pkg::NODE_W-1:0]     dest_node_i,
  input  logic [ndc_pkg::SIZE_W-1:0]     msg_size_i,
  input  logic [ndc_pkg::TIME_W-1:0]     current_time_i,
  input  logic [ndc_pkg::WORD_W-1:0]     random_word_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [ndc_pkg::TIME_W-1:0]     out_delay_o,
  output logic                           out_free_o
);

  localparam int TW = ndc_pkg::TIME_W;

  // captured request
  logic [ndc_pkg::NODE_W-1:0]      src_q, dst_q;
  logic [ndc_pkg::SIZE_W-1:0]      size_q;
  logic [TW-1:0]                   now_q;
  logic [ndc_pkg::WORD_W-1:0]      word_q, word_d;
  logic [ndc_pkg::SPAN_W-1:0]      rem_q, rem_d;

  logic [ndc_pkg::PACKET_W-1:0]    packet_q;
  logic [ndc_pkg::LOAD_W-1:0]      load_q;
  logic [TW-1:0]                   base_q, base_d;
  logic [TW-1:0]                   delay_q;
  logic [ndc_pkg::COUNT_W-1:0]     transit_q;

  // arrival table
  logic [TW-1:0]                      mem_q [ndc_pkg::TABLE_DEPTH];
  logic [ndc_pkg::TABLE_DEPTH-1:0]    valid_q;
  logic [TW-1:0]                      rd_data_q;
  logic                               rd_valid_q;
  logic [ndc_pkg::TABLE_IDX_W-1:0]    idx;
  logic                               in_range;
  logic                               random_mode;
  logic                               order_en;
  logic [TW-1:0]                      last;
  logic                               tbl_we;
  logic [TW-1:0]                      tbl_wdata;

  logic                               out_valid_q;
  logic [TW-1:0]                      out_delay_q;

  logic [ndc_pkg::WORD_W-1:0]         rand_term;
  logic [ndc_pkg::BASE_W-1:0]         base_sum;
  logic [TW:0]                        now_plus_base;
  logic [TW:0]                        delay_sum;
  logic [TW:0]                        arrival_sum;

  assign idx = ndc_pkg::TABLE_IDX_W'(
                 32'(src_q) * 32'(ndc_pkg::NODES) + 32'(dst_q));
  assign in_range = (32'(src_q) < 32'(ndc_pkg::NODES)) &&
                    (32'(dst_q) < 32'(ndc_pkg::NODES));
  assign random_mode = (cfg_i.calc_mode != ndc_pkg::MODE_CONSTANT);
  assign order_en    = random_mode && cfg_i.enforce_order && in_range;
  assign last        = rd_valid_q ? rd_data_q : '0;

  // remainder: DIV_BITS restoring steps per cycle, word shifted out msb first
  always_comb begin
    logic [ndc_pkg::SPAN_W:0] t;
    logic [ndc_pkg::SPAN_W-1:0] r;
    logic [ndc_pkg::WORD_W-1:0] w;
    r = rem_q;
    w = word_q;
    for (int k = 0; k < ndc_pkg::DIV_BITS; k++) begin
      t = {r, w[ndc_pkg::WORD_W-1]};
      w = {w[ndc_pkg::WORD_W-2:0], 1'b0};
      if (t >= {1'b0, cfg_i.random_span}) begin
        t = t - {1'b0, cfg_i.random_span};
      end
      r = t[ndc_pkg::SPAN_W-1:0];
    end
    rem_d  = r;
    word_d = w;
  end

  // zero span gives no random term; otherwise the remainder is below the word
  assign rand_term = (cfg_i.random_span == '0) ? '0 : rem_q[ndc_pkg::WORD_W-1:0];

  always_comb begin
    base_sum = ndc_pkg::BASE_W'(cfg_i.base_time);
    if (random_mode) begin
      base_sum = base_sum + ndc_pkg::BASE_W'(rand_term);
      if (cfg_i.calc_mode[1]) begin
        base_sum = base_sum + ndc_pkg::BASE_W'(load_q);
      end
    end
  end

  assign now_plus_base = {1'b0, now_q} + {1'b0, base_q};

  always_comb begin
    base_d = base_q;
    if (order_en && ({1'b0, last} > now_plus_base)) begin
      base_d = last - now_q;
    end
  end

  assign delay_sum   = {1'b0, base_q} + (TW + 1)'(packet_q);
  assign arrival_sum = {1'b0, now_q} + {1'b0, delay_q};
  assign tbl_we      = cmd_i.out_load && order_en;
  assign tbl_wdata   = ndc_pkg::sat_time(arrival_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q  <= source_node_i;
      dst_q  <= dest_node_i;
      size_q <= msg_size_i;
      now_q  <= current_time_i;
      word_q <= random_word_i;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      word_q <= word_d;
      rem_q  <= rem_d;
    end
    // products settle while the remainder unit runs
    packet_q <= ndc_pkg::PACKET_W'(size_q) * ndc_pkg::PACKET_W'(cfg_i.per_byte_time);
    load_q   <= ndc_pkg::LOAD_W'((32'(transit_q) * 32'(cfg_i.per_packet_q8)) >> 8);
    if (cmd_i.base) begin
      base_q <= TW'(base_sum);
    end else if (cmd_i.order) begin
      base_q <= base_d;
    end
    if (cmd_i.sum) begin
      delay_q <= ndc_pkg::sat_time(delay_sum);
    end
    if (cmd_i.out_load) begin
      out_delay_q <= delay_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      mem_q[idx] <= tbl_wdata;
    end
    rd_data_q <= mem_q[idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      transit_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[idx];
      if (tbl_we) begin
        valid_q[idx] <= 1'b1;
      end
      if (cmd_i.dec && (transit_q != '0)) begin
        transit_q <= transit_q - 1'b1;
      end else if (cmd_i.out_load && (transit_q != ndc_pkg::MAX_COUNT)) begin
        transit_q <= transit_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_delay_o = out_delay_q;

endmodule

// ===== src/network_delay_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_delay_calculator
// Latency model for a simulated network: one delay per send request.
// ----------------------------------------------------------------------------
// A send request steps from acceptance to the result register through the
// remainder unit (four bits of the random word a cycle), then the base sum,
// the ordering check against the per pair arrival table, the final sum and
// the hand-over, and no request is taken while a send is in flight.
// A new request is accepted once the previous send has reached the output
// register, so a single waiting result does not hold up the next one; a send
// that finds the output register full waits in its hand-over step until
// it is taken. A delivery request is taken in the idle state and gives no
// result. The arrival table is reset through one valid bit per entry, so no
// clearing pass is needed.
module network_delay_calculator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ndc_in_if.sink                         in_ch,
  ndc_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [ndc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ndc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ndc_pkg::cfg_t         cfg;
  ndc_pkg::ctrl_cmd_t    cmd;
  ndc_pkg::ctrl_status_t status;
  logic                  in_ready;
  logic                  out_free;

  assign status.in_valid     = in_ch.valid;
  assign status.in_delivered = (in_ch.req_type == ndc_pkg::REQ_DELIVERED);
  assign status.out_free     = out_free;
  assign in_ch.ready         = in_ready;

  ndc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ndc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  ndc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .source_node_i  (in_ch.source_node),
    .dest_node_i    (in_ch.dest_node),
    .msg_size_i     (in_ch.msg_size),
    .current_time_i (in_ch.current_time),
    .random_word_i  (in_ch.random_word),
    .out_ready_i    (out_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_delay_o    (out_ch.delay),
    .out_free_o     (out_free)
  );

endmodule

// ===== tb/network_delay_calculator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_delay_calculator_tb
// Self-checking bench for the network delay calculator. A driver feeds send
// and delivery requests in random bursts, and the result side stalls on a
// rotating pattern. Every accepted request runs through a local delay
// predictor with its own arrival table and in-transit count. Each returned
// delay is checked against the oldest prediction. Register settings change
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module network_delay_calculator_tb;
  import ndc_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 45;
  localparam int MAX_REPORTS    = 100;

  typedef struct {
    req_type_e           kind;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [SIZE_W-1:0]   size;
    logic [TIME_W-1:0]   now;
    logic [WORD_W-1:0]   word;
  } net_req_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ndc_in_if  in_ch ();
  ndc_out_if out_ch ();

  network_delay_calculator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state and its copy of the registers
  calc_mode_e           mode_q;
  logic [TIME16_W-1:0]  base_q;
  logic [SPAN_W-1:0]    span_q;
  logic [TIME16_W-1:0]  byte_q;
  logic [TIME16_W-1:0]  pkt_q;
  bit                   order_q;
  logic [TIME_W-1:0]    arrival_tbl [TABLE_DEPTH];
  logic [COUNT_W-1:0]   transit_cnt;

  net_req_t             pending_reqs [$];
  logic [TIME_W-1:0]    expected_delays [$];

  net_req_t             next_req;
  net_req_t             seen_req;
  logic [TIME_W-1:0]    want_delay;
  logic [TIME_W-1:0]    tick_now;
  logic [15:0]          stall_pattern;
  bit                   in_fire;
  bit                   out_fire;
  bit                   stall_mode;
  int                   idle_max;
  int                   burst_left;
  int                   gap_left;
  int                   stall_age;
  int                   idle_cycles;
  int                   error_count;
  int                   sends_seen;
  int                   deliveries_seen;
  int                   delays_checked;
  int                   settings_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TIME_W-1:0] clip_time(input logic [63:0] v);
    return (v > 64'(MAX_TIME)) ? MAX_TIME : v[TIME_W-1:0];
  endfunction

  // returns 1 with the expected delay for a send, 0 for a delivery
  function automatic bit predict_delay(input net_req_t r, output logic [TIME_W-1:0] d);
    logic [63:0] base;
    logic [63:0] packet;
    logic [63:0] last;
    logic [7:0]  idx;
    bit          rnd;
    d = '0;
    if (r.kind == REQ_DELIVERED) begin
      if (transit_cnt != '0) transit_cnt--;
      return 1'b0;
    end
    rnd    = (mode_q != MODE_CONSTANT);
    base   = 64'(base_q);
    packet = 64'(r.size) * 64'(byte_q);
    if (rnd) begin
      if (span_q != '0) base += 64'(r.word) % 64'(span_q);
      // load term uses the count before this send
      if (mode_q[1]) base += (64'(transit_cnt) * 64'(pkt_q)) >> 8;
    end
    if (rnd && order_q) begin
      idx  = {r.src, r.dst};
      last = 64'(arrival_tbl[idx]);
      if (last > 64'(r.now) + base) base = last - 64'(r.now);
      d = clip_time(base + packet);
      arrival_tbl[idx] = clip_time(64'(r.now) + 64'(d));
    end else begin
      d = clip_time(base + packet);
    end
    if (transit_cnt != MAX_COUNT) transit_cnt++;
    return 1'b1;
  endfunction

  function automatic void queue_req(input req_type_e kind, input logic [NODE_W-1:0] src,
                                    input logic [NODE_W-1:0] dst,
                                    input logic [SIZE_W-1:0] size,
                                    input logic [TIME_W-1:0] now,
                                    input logic [WORD_W-1:0] word);
    net_req_t r;
    r.kind = kind;
    r.src  = src;
    r.dst  = dst;
    r.size = size;
    r.now  = now;
    r.word = word;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic logic [TIME16_W-1:0] pick_edge16();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return TIME16_W'($urandom());
    endcase
  endfunction

  // mostly a few busy pairs with a slowly advancing clock, so ordering bites
  task automatic queue_random(input int count);
    req_type_e           kind;
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [SIZE_W-1:0]   size;
    logic [WORD_W-1:0]   word;
    logic [63:0]         wide;
    for (int i = 0; i < count; i++) begin
      kind = ($urandom_range(0, 99) < 65) ? REQ_SENT : REQ_DELIVERED;
      if ($urandom_range(0, 3) != 0) begin
        src = NODE_W'($urandom_range(0, 3));
        dst = NODE_W'($urandom_range(0, 3));
      end else begin
        src = NODE_W'($urandom());
        dst = NODE_W'($urandom());
      end
      case ($urandom_range(0, 7))
        0:       size = '0;
        1:       size = '1;
        2, 3:    size = SIZE_W'($urandom_range(0, 63));
        default: size = SIZE_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = WORD_W'($urandom());
      endcase
      case ($urandom_range(0, 15))
        0: begin
          wide     = {$urandom(), $urandom()};
          tick_now = wide[TIME_W-1:0];
        end
        1:       tick_now = MAX_TIME - TIME_W'($urandom_range(0, 1000));
        default: tick_now = tick_now + TIME_W'($urandom_range(0, 32'd1 << $urandom_range(0, 20)));
      endcase
      queue_req(kind, src, dst, size, tick_now, word);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_delays.size() != 0);
    // a delivery may still be in the block after the last delay has come
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      CFG_CALC_MODE:     mode_q  = calc_mode_e'(value[MODE_W-1:0]);
      CFG_BASE_TIME:     base_q  = value[TIME16_W-1:0];
      CFG_RANDOM_SPAN:   span_q  = value[SPAN_W-1:0];
      CFG_PER_BYTE_TIME: byte_q  = value[TIME16_W-1:0];
      CFG_PER_PACKET_Q8: pkt_q   = value[TIME16_W-1:0];
      CFG_ENFORCE_ORDER: order_q = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input calc_mode_e mode, input logic [TIME16_W-1:0] base,
                                input logic [SPAN_W-1:0] span,
                                input logic [TIME16_W-1:0] per_byte,
                                input logic [TIME16_W-1:0] per_pkt, input bit order);
    wait_idle();
    write_reg(CFG_CALC_MODE,     CFG_DATA_W'(mode));
    write_reg(CFG_BASE_TIME,     CFG_DATA_W'(base));
    write_reg(CFG_RANDOM_SPAN,   CFG_DATA_W'(span));
    write_reg(CFG_PER_BYTE_TIME, CFG_DATA_W'(per_byte));
    write_reg(CFG_PER_PACKET_Q8, CFG_DATA_W'(per_pkt));
    write_reg(CFG_ENFORCE_ORDER, CFG_DATA_W'(order));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  // request driver: bursts of random length, random gaps between them
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (gap_left != 0 || pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_req = pending_reqs.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= next_req.kind;
        in_ch.source_node  <= next_req.src;
        in_ch.dest_node    <= next_req.dst;
        in_ch.msg_size     <= next_req.size;
        in_ch.current_time <= next_req.now;
        in_ch.random_word  <= next_req.word;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          gap_left   = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
        end
      end
    end
  end

  // result side: rotating stall pattern, redrawn now and then
  always @(negedge clk_i) begin
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    stall_age++;
    if (stall_age >= 40) begin
      stall_age = 0;
      if ($urandom_range(0, 1) != 0) begin
        stall_pattern = 16'($urandom() & $urandom()) | 16'h0001;
      end else begin
        stall_pattern = 16'($urandom() | $urandom()) | 16'h0001;
      end
    end
    out_ch.ready <= !stall_mode || stall_pattern[0];
  end

  always @(posedge clk_i) begin
    in_fire  = 1'b0;
    out_fire = 1'b0;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        out_fire = 1'b1;
        if (expected_delays.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: delay %0d returned with none expected", $time, out_ch.delay);
        end else begin
          want_delay = expected_delays.pop_front();
          delays_checked++;
          if (out_ch.delay !== want_delay) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: delay mismatch, expected %0d, actual %0d",
                       $time, want_delay, out_ch.delay);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_fire           = 1'b1;
        seen_req.kind     = req_type_e'(in_ch.req_type);
        seen_req.src      = in_ch.source_node;
        seen_req.dst      = in_ch.dest_node;
        seen_req.size     = in_ch.msg_size;
        seen_req.now      = in_ch.current_time;
        seen_req.word     = in_ch.random_word;
        if (predict_delay(seen_req, want_delay)) expected_delays = {expected_delays, want_delay};
        if (seen_req.kind == REQ_SENT) sends_seen++;
        else deliveries_seen++;
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or delay accepted for %0d cycles, %0d delays outstanding",
                 $time, idle_cycles, expected_delays.size());
        $display("network_delay_calculator verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [SPAN_W-1:0] span_pick;
    logic [63:0]       seed_time;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = 1'b0;
    in_ch.source_node  = '0;
    in_ch.dest_node    = '0;
    in_ch.msg_size     = '0;
    in_ch.current_time = '0;
    in_ch.random_word  = '0;
    out_ch.ready       = 1'b0;

    mode_q       = MODE_CONSTANT;
    base_q       = '0;
    span_q       = SPAN_W'(1);
    byte_q       = '0;
    pkt_q        = '0;
    order_q      = 1'b1;
    transit_cnt  = '0;
    foreach (arrival_tbl[i]) arrival_tbl[i] = '0;

    stall_pattern = 16'hA5F1;
    stall_mode    = 1'b1;
    idle_max      = 3;
    burst_left    = 1;
    gap_left      = 0;
    seed_time     = {$urandom(), $urandom()};
    tick_now      = seed_time[TIME_W-1:0];

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: delivery with nothing in transit, then sends at the extremes
    queue_req(REQ_DELIVERED, 4'd15, 4'd15, '1, '1, '1);
    queue_req(REQ_SENT, 4'd0, 4'd15, '1, MAX_TIME, '1);
    queue_req(REQ_SENT, 4'd15, 4'd0, '0, '0, '0);

    // random mode with zero span; second send to the pair is held back
    apply_settings(MODE_RANDOM, '1, '0, '1, '1, 1'b1);
    queue_req(REQ_SENT, 4'd3, 4'd4, '1, '0, '1);
    queue_req(REQ_SENT, 4'd3, 4'd4, '0, '0, '0);
    queue_req(REQ_DELIVERED, 4'd3, 4'd4, '0, '0, '0);

    // mode three, span above the word range; arrival saturates, then the delay
    apply_settings(MODE_LOADED_X, '0, SPAN_W'(65536), TIME16_W'(1), '1, 1'b1);
    queue_req(REQ_SENT, 4'd15, 4'd0, '1, MAX_TIME - TIME_W'(10), '1);
    queue_req(REQ_SENT, 4'd15, 4'd0, '1, '0, '1);
    queue_req(REQ_SENT, 4'd0, 4'd0, '0, '0, '0);
    queue_req(REQ_DELIVERED, 4'd0, 4'd0, '0, '0, '0);
    queue_req(REQ_DELIVERED, 4'd0, 4'd0, '0, '0, '0);

    // load term with ordering off
    apply_settings(MODE_LOADED, TIME16_W'(100), '1, TIME16_W'(3), TIME16_W'(384), 1'b0);
    queue_req(REQ_SENT, 4'd15, 4'd0, SIZE_W'(7), '0, WORD_W'(1234));
    queue_req(REQ_SENT, 4'd15, 4'd0, '1, TIME_W'(5), '1);

    // constant mode leaves the table alone even with ordering on
    apply_settings(MODE_CONSTANT, '1, SPAN_W'(1), '1, '0, 1'b1);
    queue_req(REQ_SENT, 4'd15, 4'd0, '1, '0, '1);
    queue_req(REQ_SENT, 4'd3, 4'd4, SIZE_W'(1), '0, '0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       span_pick = '0;
        1:       span_pick = SPAN_W'(1);
        2:       span_pick = SPAN_W'(65535);
        3:       span_pick = SPAN_W'(65536);
        4:       span_pick = '1;
        default: span_pick = SPAN_W'($urandom_range(2, 300));
      endcase
      apply_settings(calc_mode_e'(p % 4), pick_edge16(), span_pick, pick_edge16(),
                     pick_edge16(), (p % 3) != 2);
      idle_max   = (p % 2 == 0) ? 0 : $urandom_range(1, 12);
      stall_mode = (p % 3 != 0);
      queue_random(PHASE_ITEMS);
    end

    // load term at the largest cost with the count built up, deliveries pulling it down
    apply_settings(MODE_LOADED, pick_edge16(), SPAN_W'($urandom_range(1, 5000)), pick_edge16(),
                   '1, 1'b1);
    idle_max   = 6;
    stall_mode = 1'b1;
    queue_random(30);

    wait_idle();
    $display("checked %0d delays from %0d sends and %0d deliveries",
             delays_checked, sends_seen, deliveries_seen);
    $display("%0d register settings, all modes, span and cost extremes, ordered pairs",
             settings_count);
    if (error_count == 0) begin
      $display("network_delay_calculator verification clean");
    end else begin
      $display("network_delay_calculator verification failed");
    end
    $finish;
  end

endmodule
